[rtl/core/ctr_pkg.sv]
// Shared types, constants and functions for the colour temperature to RGB unit.
// Depends on nothing; every other file of the block imports it.
package ctr_pkg;

    // Field widths fixed by the channel payloads
    localparam int T_W     = 16;
    localparam int LEVEL_W = 8;

    // Divide by 100 through a reciprocal: exact for every 24-bit dividend
    localparam int          DIV_IN_W    = 24;
    localparam int          RECIP_SHIFT = 31;
    localparam int          RECIP_W     = 25;
    localparam int          PROD_W      = DIV_IN_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_MULT = 25'd21474837;
    localparam logic [7:0]  DIV_BIAS    = 8'd50;

    // Internal fixed-point widths
    localparam int X_W       = 18;   // Q10.8 temperature scale
    localparam int P_W       = 5;    // leading-one position
    localparam int FRAC_W    = 16;   // mantissa fraction
    localparam int E_W       = 12;   // log table entry, Q.12
    localparam int LN_W      = 17;   // signed Q4.12 log
    localparam int OFF_W     = 6;
    localparam int COEF_A_W  = 22;
    localparam int COEF_B_W  = 13;
    localparam int COEF_C_W  = 20;
    localparam int BX_W      = COEF_B_W + X_W + 1;
    localparam int CL_W      = COEF_C_W + LN_W;
    localparam int SUM_W     = 40;
    localparam int ROUND_POS = 24;

    localparam int LN2_Q12       = 2839;
    localparam int SERIES_TERMS  = 30;
    localparam int X_FRAC_BITS   = 8;

    // Temperature break points in kelvin
    localparam logic [T_W-1:0] T_KNEE       = 16'd6600;
    localparam logic [T_W-1:0] T_GREEN_ZERO = 16'd1000;
    localparam logic [T_W-1:0] T_BLUE_ZERO  = 16'd2000;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;

    // Lanes
    localparam int NUM_LANES  = 3;
    localparam int LANE_RED   = 0;
    localparam int LANE_GREEN = 1;
    localparam int LANE_BLUE  = 2;

    typedef enum logic [1:0] {
        MODE_FIT  = 2'd0,
        MODE_ZERO = 2'd1,
        MODE_FULL = 2'd2
    } t_chan_mode;

    typedef enum logic [1:0] {
        FIT_RED        = 2'd0,
        FIT_GREEN_WARM = 2'd1,
        FIT_GREEN_COOL = 2'd2,
        FIT_BLUE       = 2'd3
    } t_fit_sel;

    typedef struct packed {
        t_chan_mode mode;
        t_fit_sel   sel;
    } t_lane_tag;

    typedef struct packed {
        logic        [OFF_W-1:0]    offset;
        logic signed [COEF_A_W-1:0] a;
        logic signed [COEF_B_W-1:0] b;
        logic signed [COEF_C_W-1:0] c;
    } t_coef;

    typedef struct packed {
        t_lane_tag        tag;
        logic [X_W-1:0]   x;
    } t_lane_x;

    typedef struct packed {
        t_lane_tag               tag;
        logic        [X_W-1:0]   x;
        logic signed [LN_W-1:0]  lnx;
    } t_lane_ln;

    typedef t_lane_x  [NUM_LANES-1:0] t_word_x;
    typedef t_lane_ln [NUM_LANES-1:0] t_word_ln;

    typedef struct packed {
        logic [LEVEL_W-1:0] red_level;
        logic [LEVEL_W-1:0] green_level;
        logic [LEVEL_W-1:0] blue_level;
    } t_rgb;

    // Fit coefficients: offset in hundreds of kelvin, a, b, c in Q.12
    function automatic t_coef fit_coef(input t_fit_sel sel);
        t_coef cf;
        unique case (sel)
            FIT_RED: begin
                cf.offset = 6'd55;
                cf.a      = 22'sd1441669;
                cf.b      = 13'sd451;
                cf.c      = -20'sd164864;
            end
            FIT_GREEN_WARM: begin
                cf.offset = 6'd2;
                cf.a      = -22'sd635904;
                cf.b      = -13'sd1802;
                cf.c      = 20'sd427991;
            end
            FIT_GREEN_COOL: begin
                cf.offset = 6'd50;
                cf.a      = 22'sd1333043;
                cf.b      = 13'sd328;
                cf.c      = -20'sd115016;
            end
            FIT_BLUE: begin
                cf.offset = 6'd10;
                cf.a      = -22'sd1043538;
                cf.b      = 13'sd3400;
                cf.c      = 20'sd473825;
            end
        endcase
        return cf;
    endfunction

    // ln(1 + i/N) in Q.12 from z = i/(2N+i) in Q.30: 2*atanh(z), rounded half up
    function automatic logic [63:0] log_series(input logic [63:0] z);
        logic [63:0] z2;
        logic [63:0] term;
        logic [63:0] sum;
        z2   = (z * z) >> 30;
        term = z;
        sum  = 64'd0;
        for (int k = 0; k < SERIES_TERMS; k++) begin
            sum  = sum + term / 64'(2 * k + 1);
            term = (term * z2) >> 30;
        end
        return (64'd2 * sum + (64'd1 << 17)) >> 18;
    endfunction

endpackage

[rtl/core/ctr_temp_if.sv]
// Input channel of the colour temperature unit: one temperature word per handshake.
// Depends on ctr_pkg for the field width.
interface ctr_temp_if import ctr_pkg::*; ();
    logic           valid;
    logic           ready;
    logic [T_W-1:0] temperature_kelvin;

    modport source (output valid, output temperature_kelvin, input ready);
    modport sink   (input valid, input temperature_kelvin, output ready);
endinterface

[rtl/core/ctr_rgb_if.sv]
// Output channel of the colour temperature unit: one RGB level word per handshake.
// Depends on ctr_pkg for the field widths.
interface ctr_rgb_if import ctr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] red_level;
    logic [LEVEL_W-1:0] green_level;
    logic [LEVEL_W-1:0] blue_level;

    modport source (output valid, output red_level, output green_level,
                    output blue_level, input ready);
    modport sink   (input valid, input red_level, input green_level,
                    input blue_level, output ready);
endinterface

[rtl/core/colour_temperature_to_rgb_unit.sv]
// Top level of the colour temperature to RGB unit: scale, log and fit pipelines.
// Depends on ctr_pkg, ctr_temp_if, ctr_rgb_if, ctr_scale, ctr_log and ctr_fit.
//
//  channel   dir  payload                                 word per handshake
//  i_temp    in   temperature_kelvin[15:0]                one temperature
//  o_rgb     out  red_level, green_level, blue_level [7:0] one RGB result
//
// Throughput is one word per cycle while o_rgb is not stalled; there is one register
// per stage (two in the scale front end, four in the log unit, two in the fit unit).
// Reset is synchronous and clears only the valid bits of the stages.
// A stage holds its word while its successor is full and not moving, so a
// stall ripples back stage by stage and empty stages keep filling.
module colour_temperature_to_rgb_unit import ctr_pkg::*; #(
    parameter int LOG_TABLE_ENTRIES = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ctr_temp_if.sink          i_temp,
    ctr_rgb_if.source         o_rgb
);

    logic     scale_vld;
    logic     scale_rdy;
    t_word_x  scale_word;
    logic     log_vld;
    logic     log_rdy;
    t_word_ln log_word;
    t_rgb     fit_word;

    ctr_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_temp.valid),
        .o_ready (i_temp.ready),
        .i_temp  (i_temp.temperature_kelvin),
        .o_valid (scale_vld),
        .i_ready (scale_rdy),
        .o_word  (scale_word)
    );

    ctr_log #(
        .LOG_TABLE_ENTRIES (LOG_TABLE_ENTRIES)
    ) u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (scale_vld),
        .o_ready (scale_rdy),
        .i_word  (scale_word),
        .o_valid (log_vld),
        .i_ready (log_rdy),
        .o_word  (log_word)
    );

    ctr_fit u_fit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (log_vld),
        .o_ready (log_rdy),
        .i_word  (log_word),
        .o_valid (o_rgb.valid),
        .i_ready (o_rgb.ready),
        .o_word  (fit_word)
    );

    // Drive the output payload
    assign o_rgb.red_level   = fit_word.red_level;
    assign o_rgb.green_level = fit_word.green_level;
    assign o_rgb.blue_level  = fit_word.blue_level;

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_rgb.valid)
        else $error("output valid after reset");

    // A free-running sink must never throttle the source
    a_ready_chain: assert property (@(posedge i_clk) o_rgb.ready |-> i_temp.ready)
        else $error("input stalled while output is ready");

    // A fitted red level only occurs at or above the knee, where blue is full
    a_red_blue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rgb.valid && o_rgb.red_level != LEVEL_MAX) |-> o_rgb.blue_level == LEVEL_MAX)
        else $error("red below full scale without full blue");

endmodule

[rtl/core/ctr_scale.sv]
// Front end: scales kelvin to Q10.8 hundreds, picks each lane's fit and offset.
// Two pipeline stages; depends on ctr_pkg.
module ctr_scale import ctr_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [T_W-1:0] i_temp,
    output logic           o_valid,
    input  logic           i_ready,
    output t_word_x        o_word
);

    logic [1:0] r_vld;
    logic       en0;
    logic       en1;

    logic [PROD_W-1:0]              r_prod;
    t_lane_tag [NUM_LANES-1:0]      r_tag;
    t_word_x                        r_word;

    logic [DIV_IN_W-1:0]            dividend;
    logic [PROD_W-1:0]              prod;
    t_lane_tag [NUM_LANES-1:0]      tag;
    logic [X_W-1:0]                 q;
    t_coef                          cf [NUM_LANES];
    logic signed [X_W:0]            xs [NUM_LANES];
    t_word_x                        word;

    // Stage enables: a stage loads when empty or when its successor moves
    assign en1     = !r_vld[1] || i_ready;
    assign en0     = !r_vld[0] || en1;
    assign o_ready = en0;
    assign o_valid = r_vld[1];
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en0) r_vld[0] <= i_valid;
            if (en1) r_vld[1] <= r_vld[0];
        end
    end

    // Stage 0: (256*T + 50) times the reciprocal of 100, and lane selection
    assign dividend = {i_temp, DIV_BIAS};
    assign prod     = PROD_W'(dividend) * PROD_W'(RECIP_MULT);

    always_comb begin
        tag[LANE_RED].sel = FIT_RED;
        if (i_temp < T_KNEE) tag[LANE_RED].mode = MODE_FULL;
        else                 tag[LANE_RED].mode = MODE_FIT;

        if (i_temp <= T_GREEN_ZERO) begin
            tag[LANE_GREEN].mode = MODE_ZERO;
            tag[LANE_GREEN].sel  = FIT_GREEN_WARM;
        end else if (i_temp < T_KNEE) begin
            tag[LANE_GREEN].mode = MODE_FIT;
            tag[LANE_GREEN].sel  = FIT_GREEN_WARM;
        end else begin
            tag[LANE_GREEN].mode = MODE_FIT;
            tag[LANE_GREEN].sel  = FIT_GREEN_COOL;
        end

        tag[LANE_BLUE].sel = FIT_BLUE;
        if (i_temp <= T_BLUE_ZERO) tag[LANE_BLUE].mode = MODE_ZERO;
        else if (i_temp < T_KNEE)  tag[LANE_BLUE].mode = MODE_FIT;
        else                       tag[LANE_BLUE].mode = MODE_FULL;
    end

    always_ff @(posedge i_clk) begin
        if (en0) begin
            r_prod <= prod;
            r_tag  <= tag;
        end
    end

    // Stage 1: subtract the lane offset, floor at one
    assign q = r_prod[PROD_W-1:RECIP_SHIFT];

    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            cf[l] = fit_coef(r_tag[l].sel);
            xs[l] = $signed({1'b0, q})
                  - $signed((X_W+1)'({cf[l].offset, {X_FRAC_BITS{1'b0}}}));
            word[l].tag = r_tag[l];
            if (xs[l] <= 0) word[l].x = X_W'(1);
            else            word[l].x = xs[l][X_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) r_word <= word;
    end

endmodule

[rtl/core/ctr_log.sv]
// Natural log unit: leading-one search, normalise, interpolated table, ln 2 scaling.
// Four pipeline stages over all three lanes; depends on ctr_pkg.
module ctr_log import ctr_pkg::*; #(
    parameter int LOG_TABLE_ENTRIES = 64
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_word_x  i_word,
    output logic     o_valid,
    input  logic     i_ready,
    output t_word_ln o_word
);

    localparam int AW = $clog2(LOG_TABLE_ENTRIES + 1);
    localparam int SW = FRAC_W + AW;
    localparam int MW = E_W + FRAC_W;

    logic [3:0] r_vld;
    logic       en0;
    logic       en1;
    logic       en2;
    logic       en3;

    // ln(1 + i/N) table, built at elaboration
    logic [E_W-1:0] log_tab [0:LOG_TABLE_ENTRIES];

    for (genvar gi = 0; gi <= LOG_TABLE_ENTRIES; gi++) begin : g_tab
        localparam logic [63:0] Z =
            (64'(gi) << 30) / 64'(2 * LOG_TABLE_ENTRIES + gi);
        localparam logic [E_W-1:0] ENTRY = E_W'(log_series(Z));
        assign log_tab[gi] = ENTRY;
    end

    t_word_x           r0_word;
    logic [P_W-1:0]    r0_p    [NUM_LANES];
    t_word_x           r1_word;
    logic [P_W-1:0]    r1_p    [NUM_LANES];
    logic [AW-1:0]     r1_idx  [NUM_LANES];
    logic [FRAC_W-1:0] r1_rem  [NUM_LANES];
    t_word_x           r2_word;
    logic [P_W-1:0]    r2_p    [NUM_LANES];
    logic [E_W-1:0]    r2_e0   [NUM_LANES];
    logic [E_W-1:0]    r2_diff [NUM_LANES];
    logic [FRAC_W-1:0] r2_rem  [NUM_LANES];
    t_word_ln          r3_word;

    logic [P_W-1:0]         lz_p   [NUM_LANES];
    logic [P_W-1:0]         sh     [NUM_LANES];
    logic [X_W-1:0]         norm   [NUM_LANES];
    logic [SW-1:0]          scaled [NUM_LANES];
    logic [AW-1:0]          idx_nx [NUM_LANES];
    logic [E_W-1:0]         e0     [NUM_LANES];
    logic [E_W-1:0]         e1     [NUM_LANES];
    logic [MW:0]            mix    [NUM_LANES];
    logic [E_W:0]           interp [NUM_LANES];
    logic signed [LN_W-1:0] pm8    [NUM_LANES];
    logic signed [LN_W-1:0] ln_base[NUM_LANES];
    t_word_ln               word;

    // Stage enables
    assign en3     = !r_vld[3] || i_ready;
    assign en2     = !r_vld[2] || en3;
    assign en1     = !r_vld[1] || en2;
    assign en0     = !r_vld[0] || en1;
    assign o_ready = en0;
    assign o_valid = r_vld[3];
    assign o_word  = r3_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en0) r_vld[0] <= i_valid;
            if (en1) r_vld[1] <= r_vld[0];
            if (en2) r_vld[2] <= r_vld[1];
            if (en3) r_vld[3] <= r_vld[2];
        end
    end

    // Stage 0: find the leading one of x
    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            lz_p[l] = '0;
            for (int b = 0; b < X_W; b++) begin
                if (i_word[l].x[b]) lz_p[l] = P_W'(b);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en0) begin
            r0_word <= i_word;
            r0_p    <= lz_p;
        end
    end

    // Stage 1: normalise and split the fraction into table index and remainder
    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            sh[l]     = P_W'(X_W - 1) - r0_p[l];
            norm[l]   = r0_word[l].x << sh[l];
            scaled[l] = SW'(norm[l][X_W-2:X_W-1-FRAC_W]) * SW'(LOG_TABLE_ENTRIES);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_word <= r0_word;
            r1_p    <= r0_p;
            for (int l = 0; l < NUM_LANES; l++) begin
                r1_idx[l] <= scaled[l][SW-1:FRAC_W];
                r1_rem[l] <= scaled[l][FRAC_W-1:0];
            end
        end
    end

    // Stage 2: read the two neighbouring entries
    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            idx_nx[l] = r1_idx[l] + AW'(1);
            e0[l]     = log_tab[r1_idx[l]];
            e1[l]     = log_tab[idx_nx[l]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_word <= r1_word;
            r2_p    <= r1_p;
            r2_rem  <= r1_rem;
            for (int l = 0; l < NUM_LANES; l++) begin
                r2_e0[l]   <= e0[l];
                r2_diff[l] <= e1[l] - e0[l];
            end
        end
    end

    // Stage 3: interpolate, round half up, add the octave term
    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            mix[l]     = (MW+1)'(r2_diff[l]) * (MW+1)'(r2_rem[l])
                       + (MW+1)'(1 << (FRAC_W - 1));
            interp[l]  = (E_W+1)'(r2_e0[l]) + (E_W+1)'(mix[l][MW:FRAC_W]);
            pm8[l]     = $signed(LN_W'(r2_p[l])) - $signed(LN_W'(X_FRAC_BITS));
            ln_base[l] = pm8[l] * $signed(LN_W'(LN2_Q12));
            word[l].tag = r2_word[l].tag;
            word[l].x   = r2_word[l].x;
            word[l].lnx = ln_base[l] + $signed(LN_W'(interp[l]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) r3_word <= word;
    end

endmodule

[rtl/core/ctr_fit.sv]
// Fit evaluation: a + b*x + c*ln(x) per lane, rounding, clamping, fixed levels.
// Two pipeline stages; the last one is the output register. Depends on ctr_pkg.
module ctr_fit import ctr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_word_ln i_word,
    output logic     o_valid,
    input  logic     i_ready,
    output t_rgb     o_word
);

    logic [1:0] r_vld;
    logic       en0;
    logic       en1;

    t_lane_tag [NUM_LANES-1:0] r0_tag;
    logic signed [BX_W-1:0]    r0_bx [NUM_LANES];
    logic signed [CL_W-1:0]    r0_cl [NUM_LANES];
    t_rgb                      r1_word;

    t_coef                     cf_in  [NUM_LANES];
    t_coef                     cf_sum [NUM_LANES];
    logic signed [BX_W-1:0]    bx     [NUM_LANES];
    logic signed [CL_W-1:0]    cl     [NUM_LANES];
    logic signed [SUM_W-1:0]   sum    [NUM_LANES];
    logic [SUM_W-1:0]          rnd    [NUM_LANES];
    logic [SUM_W-ROUND_POS-1:0] hi    [NUM_LANES];
    logic [LEVEL_W-1:0]        fit_lvl[NUM_LANES];
    logic [LEVEL_W-1:0]        lvl    [NUM_LANES];

    // Stage enables
    assign en1     = !r_vld[1] || i_ready;
    assign en0     = !r_vld[0] || en1;
    assign o_ready = en0;
    assign o_valid = r_vld[1];
    assign o_word  = r1_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en0) r_vld[0] <= i_valid;
            if (en1) r_vld[1] <= r_vld[0];
        end
    end

    // Stage 0: the two products
    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            cf_in[l] = fit_coef(i_word[l].tag.sel);
            bx[l] = cf_in[l].b * $signed({1'b0, i_word[l].x});
            cl[l] = cf_in[l].c * i_word[l].lnx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en0) begin
            for (int l = 0; l < NUM_LANES; l++) begin
                r0_tag[l] <= i_word[l].tag;
                r0_bx[l]  <= bx[l];
                r0_cl[l]  <= cl[l];
            end
        end
    end

    // Stage 1: sum in Q.24, round half up, clamp, then pick fixed or fitted level
    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            cf_sum[l] = fit_coef(r0_tag[l].sel);
            sum[l] = (SUM_W'(cf_sum[l].a) <<< 12) + (SUM_W'(r0_bx[l]) <<< 4)
                   + SUM_W'(r0_cl[l]);
            rnd[l] = sum[l] + (SUM_W'(1) << (ROUND_POS - 1));
            hi[l]  = rnd[l][SUM_W-1:ROUND_POS];
            if (sum[l] < 0)                             fit_lvl[l] = '0;
            else if (hi[l] > (SUM_W-ROUND_POS)'(LEVEL_MAX)) fit_lvl[l] = LEVEL_MAX;
            else                                        fit_lvl[l] = hi[l][LEVEL_W-1:0];
            unique case (r0_tag[l].mode)
                MODE_FIT:  lvl[l] = fit_lvl[l];
                MODE_ZERO: lvl[l] = '0;
                MODE_FULL: lvl[l] = LEVEL_MAX;
                default:   lvl[l] = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_word.red_level   <= lvl[LANE_RED];
            r1_word.green_level <= lvl[LANE_GREEN];
            r1_word.blue_level  <= lvl[LANE_BLUE];
        end
    end

endmodule

[bench/rgb_level_checker.sv]
`timescale 1ns / 1ps
// Checker for the colour temperature to RGB unit: predicts the RGB levels of every
// accepted temperature word and compares each result word with the oldest prediction.
// Depends on ctr_pkg, ctr_temp_if and ctr_rgb_if.
module rgb_level_checker import ctr_pkg::*; #(
    parameter int LOG_TABLE_ENTRIES = 64
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    ctr_temp_if   i_temp_ch,
    ctr_rgb_if    i_rgb_ch,
    output int    o_fail_count,
    output int    o_pending
);

    localparam longint LN_TWO_Q12    = 2839;
    localparam int     ATANH_TERMS   = 30;
    localparam int     KNEE_K        = 6600;
    localparam int     GREEN_FLOOR_K = 1000;
    localparam int     BLUE_FLOOR_K  = 2000;

    typedef struct {
        logic [T_W-1:0] kelvin;
        t_rgb           levels;
    } t_due;

    t_due levels_due [$];
    int   mismatch_count = 0;

    assign o_fail_count = mismatch_count;

    // ln(1 + i/N) in Q.12 as 2*atanh(i/(2N+i)), series summed in Q.30
    function automatic longint ln_entry(input longint unsigned i);
        longint unsigned z, z2, term, acc;
        z    = (i << 30) / (2 * LOG_TABLE_ENTRIES + i);
        z2   = (z * z) >> 30;
        term = z;
        acc  = 0;
        for (int k = 0; k < ATANH_TERMS; k++) begin
            acc  = acc + term / longint'(2 * k + 1);
            term = (term * z2) >> 30;
        end
        return longint'((2 * acc + (64'd1 << 17)) >> 18);
    endfunction

    // One fitted channel: a + b*x + c*ln(x) in Q.24, rounded and clamped
    function automatic logic [LEVEL_W-1:0] fit_level(input logic [T_W-1:0] kelvin,
                                                     input longint offset,
                                                     input longint a,
                                                     input longint b,
                                                     input longint c);
        longint          x, p, e0, e1, ln_q12, acc, level;
        longint unsigned frac, scaled, idx, rem;
        x = (longint'(kelvin) * 256 + 50) / 100 - offset * 256;
        if (x <= 0) begin
            x = 1;
        end
        // Find the leading one, then interpolate the mantissa in the table
        p = 0;
        while (p < 40 && (x >> (p + 1)) != 0) begin
            p++;
        end
        frac   = ((longint'(x) << 16) >> p) - 65536;
        scaled = frac * LOG_TABLE_ENTRIES;
        idx    = scaled >> 16;
        rem    = scaled & 64'hFFFF;
        e0     = ln_entry(idx);
        e1     = ln_entry(idx + 1);
        ln_q12 = (p - 8) * LN_TWO_Q12 + e0 + ((e1 - e0) * longint'(rem) + 32768) / 65536;
        acc    = a * 4096 + b * x * 16 + c * ln_q12;
        if (acc < 0) begin
            return '0;
        end
        level = (acc + (64'sd1 <<< 23)) >>> 24;
        if (level > 255) begin
            return 8'd255;
        end
        return level[LEVEL_W-1:0];
    endfunction

    function automatic t_rgb predict_levels(input logic [T_W-1:0] kelvin);
        t_rgb lv;
        if (kelvin < KNEE_K) begin
            lv.red_level = 8'd255;
        end else begin
            lv.red_level = fit_level(kelvin, 55, 1441669, 451, -164864);
        end
        if (kelvin <= GREEN_FLOOR_K) begin
            lv.green_level = 8'd0;
        end else if (kelvin < KNEE_K) begin
            lv.green_level = fit_level(kelvin, 2, -635904, -1802, 427991);
        end else begin
            lv.green_level = fit_level(kelvin, 50, 1333043, 328, -115016);
        end
        if (kelvin <= BLUE_FLOOR_K) begin
            lv.blue_level = 8'd0;
        end else if (kelvin < KNEE_K) begin
            lv.blue_level = fit_level(kelvin, 10, -1043538, 3400, 473825);
        end else begin
            lv.blue_level = 8'd255;
        end
        return lv;
    endfunction

    // Queue a prediction per accepted temperature; check each accepted result word
    always @(posedge i_clk) begin
        t_due due;
        if (i_rst_n) begin
            if (i_temp_ch.valid && i_temp_ch.ready) begin
                due.kelvin = i_temp_ch.temperature_kelvin;
                due.levels = predict_levels(i_temp_ch.temperature_kelvin);
                levels_due.push_back(due);
            end
            if (i_rgb_ch.valid && i_rgb_ch.ready) begin
                if (levels_due.size() == 0) begin
                    $display("%0t: unexpected result word r=%0d g=%0d b=%0d", $time,
                             i_rgb_ch.red_level, i_rgb_ch.green_level,
                             i_rgb_ch.blue_level);
                    mismatch_count++;
                end else begin
                    due = levels_due.pop_front();
                    if (i_rgb_ch.red_level !== due.levels.red_level) begin
                        $display("%0t: T=%0d red expected %0d actual %0d", $time,
                                 due.kelvin, due.levels.red_level, i_rgb_ch.red_level);
                        mismatch_count++;
                    end
                    if (i_rgb_ch.green_level !== due.levels.green_level) begin
                        $display("%0t: T=%0d green expected %0d actual %0d", $time,
                                 due.kelvin, due.levels.green_level,
                                 i_rgb_ch.green_level);
                        mismatch_count++;
                    end
                    if (i_rgb_ch.blue_level !== due.levels.blue_level) begin
                        $display("%0t: T=%0d blue expected %0d actual %0d", $time,
                                 due.kelvin, due.levels.blue_level, i_rgb_ch.blue_level);
                        mismatch_count++;
                    end
                end
            end
        end
        o_pending <= levels_due.size();
    end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// Top of the colour temperature to RGB bench: clock, reset, temperature stimulus,
// result back-pressure and the verdict. Depends on ctr_pkg, both channel
// interfaces, colour_temperature_to_rgb_unit and rgb_level_checker.
module tb import ctr_pkg::*; ();

    localparam int LOG_ENTRIES    = 64;
    localparam int ITEMS_PER_RUN  = 382;
    localparam int DRAIN_CYCLES   = 24;
    localparam int CYCLE_LIMIT    = 400000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    int fail_count;
    int pending;
    int idle_pct  = 0;
    int stall_pct = 0;
    int cycle_count = 0;

    int idle_by_phase  [4] = '{0, 62, 0, 19};
    int stall_by_phase [4] = '{0, 0, 62, 19};

    logic [T_W-1:0] corner_temps [24] = '{
        16'd0, 16'd1, 16'd999, 16'd1000, 16'd1001, 16'd1999, 16'd2000, 16'd2001,
        16'd6599, 16'd6600, 16'd6601, 16'd65535, 16'd65534, 16'd32768, 16'h5555,
        16'hAAAA, 16'd1500, 16'd3000, 16'd4500, 16'd5500, 16'd8000, 16'd12000,
        16'd25000, 16'd50000
    };

    ctr_temp_if temp_ch ();
    ctr_rgb_if  rgb_ch ();

    colour_temperature_to_rgb_unit #(
        .LOG_TABLE_ENTRIES (LOG_ENTRIES)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_temp  (temp_ch),
        .o_rgb   (rgb_ch)
    );

    rgb_level_checker #(
        .LOG_TABLE_ENTRIES (LOG_ENTRIES)
    ) levels_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_temp_ch    (temp_ch),
        .i_rgb_ch     (rgb_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    // Stall the result channel at the rate of the current phase
    always @(posedge i_clk) begin
        rgb_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Drop the run once the cycle budget is spent
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    // Offer one temperature word after a random gap and hold it until taken
    task automatic send_temperature(input logic [T_W-1:0] kelvin);
        while ($urandom_range(99) < idle_pct) begin
            temp_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        temp_ch.valid              <= 1'b1;
        temp_ch.temperature_kelvin <= kelvin;
        @(posedge i_clk);
        while (!temp_ch.ready) begin
            @(posedge i_clk);
        end
    endtask

    // Hold the sender until every predicted word has come back
    task automatic wait_drained();
        temp_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        logic [T_W-1:0] kelvin;
        int             knee;
        temp_ch.valid              = 1'b0;
        temp_ch.temperature_kelvin = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Corners and break points first, with no idling
        foreach (corner_temps[i]) begin
            send_temperature(corner_temps[i]);
        end

        for (int phase = 0; phase < 4; phase++) begin
            idle_pct  = idle_by_phase[phase];
            stall_pct = stall_by_phase[phase];
            for (int n = 0; n < ITEMS_PER_RUN; n++) begin
                case ($urandom_range(9))
                    0, 1, 2, 3: kelvin = 16'($urandom_range(6999));
                    4, 5: begin
                        case ($urandom_range(2))
                            0:       knee = 1000;
                            1:       knee = 2000;
                            default: knee = 6600;
                        endcase
                        kelvin = 16'(knee - 8 + $urandom_range(16));
                    end
                    default: kelvin = 16'($urandom_range(65535));
                endcase
                send_temperature(kelvin);
            end
            wait_drained();
        end

        // Let any stray word show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
